// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define ASSERT_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CHECK(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Types, codes and helper functions of the page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam logic [31:0] FULL_WORD  = 32'hFFFF_FFFF;
    localparam logic [31:0] POOL_BASE_RESET = 32'h4000_0000;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_RESERVED  = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] page_address;
    } t_cmd_word;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
    } t_res_word;

    // Index of the lowest clear bit; zero when the word is full.
    function automatic logic [4:0] first_zero(input logic [31:0] word);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/page_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit page allocator over a bitmap memory, one bit per page.
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_data  (pba_pkg::t_cmd_word)
// out       output     o_out_valid / i_out_ready o_out_data (pba_pkg::t_res_word)
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// Init rewrites the bitmap one word per cycle, marking the reserved pages as used.
// Alloc reads the bitmap words in turn up to the first one with a clear bit
// (at most BITMAP_WORDS) through the registered read port and sets that bit.
// Free clears the page's bit; an address outside the pool gets ST_RANGE.
// After reset a clearing pass over all BITMAP_WORDS words runs before o_in_ready.
// A new word is taken while the previous result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module page_bitmap_allocator_top #(
    parameter int unsigned BITMAP_WORDS = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  pba_pkg::t_cmd_word   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output pba_pkg::t_res_word   o_out_data,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire [31:0]           i_cfg_wdata
);

    localparam int unsigned AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned CW = (AW > 11) ? AW : 11;
    localparam logic [31:0] POOL_PAGES = 32'(BITMAP_WORDS * 32);
    localparam logic [AW-1:0] LAST_WORD = AW'(BITMAP_WORDS - 1);

    logic [31:0] mem [0:BITMAP_WORDS-1];

    pba_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_cur, n_cur;
    logic            r_init, n_init;
    logic [4:0]      r_bit, n_bit;
    logic [31:0]     r_res_addr, n_res_addr;
    logic [1:0]      r_res_st, n_res_st;
    logic            r_out_valid, n_out_valid;
    pba_pkg::t_res_word r_out, n_out;
    logic [31:0]     r_pool_base;
    logic [15:0]     r_reserved;
    logic [31:0]     r_rdata;

    logic [AW-1:0]   rd_addr;
    logic            w_en;
    logic [AW-1:0]   w_addr;
    logic [31:0]     w_data;

    logic            in_acc;
    logic [31:0]     f_diff;
    logic [31:0]     f_page;
    logic            f_out;
    logic [4:0]      fz;
    logic [31:0]     sweep_mask;
    logic [CW-1:0]   cur_ext;
    logic [CW-1:0]   rsv_words;

    assign o_in_ready  = (r_state == pba_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;

    assign f_diff = i_in_data.page_address - r_pool_base;
    assign f_page = f_diff >> pba_pkg::PAGE_SHIFT;
    assign f_out  = (i_in_data.page_address < r_pool_base) || (f_page >= POOL_PAGES);
    assign fz     = pba_pkg::first_zero(r_rdata);

    assign cur_ext   = CW'(r_cur);
    assign rsv_words = CW'(r_reserved[15:5]);

    always_comb begin
        if (!r_init) begin
            sweep_mask = '0;
        end else if (cur_ext < rsv_words) begin
            sweep_mask = pba_pkg::FULL_WORD;
        end else if (cur_ext == rsv_words) begin
            sweep_mask = (32'd1 << r_reserved[4:0]) - 32'd1;
        end else begin
            sweep_mask = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_init      = r_init;
        n_bit       = r_bit;
        n_res_addr  = r_res_addr;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_addr     = AW'(r_cur + AW'(1));
        w_en        = 1'b0;
        w_addr      = r_cur;
        w_data      = sweep_mask;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pba_pkg::S_SWEEP: begin
                w_en = 1'b1;
                n_cur = AW'(r_cur + AW'(1));
                if (r_cur == LAST_WORD) begin
                    n_cur = '0;
                    n_state = r_init ? pba_pkg::S_RESULT : pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_IDLE: begin
                rd_addr = '0;
                if (in_acc) begin
                    n_res_addr = '0;
                    n_res_st   = pba_pkg::ST_OK;
                    n_cur      = '0;
                    case (pba_pkg::t_cmd'(i_in_data.cmd))
                        pba_pkg::CMD_INIT: begin
                            n_init  = 1'b1;
                            n_state = pba_pkg::S_SWEEP;
                        end
                        pba_pkg::CMD_ALLOC: begin
                            n_state = pba_pkg::S_SCAN;
                        end
                        pba_pkg::CMD_FREE: begin
                            if (f_out) begin
                                n_res_st = pba_pkg::ST_RANGE;
                                n_state  = pba_pkg::S_RESULT;
                            end else begin
                                rd_addr = f_page[AW+4:5];
                                n_cur   = f_page[AW+4:5];
                                n_bit   = f_page[4:0];
                                n_state = pba_pkg::S_FREE;
                            end
                        end
                        default: begin
                            n_state = pba_pkg::S_RESULT;
                        end
                    endcase
                end
            end
            pba_pkg::S_SCAN: begin
                if (r_rdata != pba_pkg::FULL_WORD) begin
                    w_en       = 1'b1;
                    w_data     = r_rdata | (32'd1 << fz);
                    n_res_addr = r_pool_base + (32'({r_cur, fz}) << pba_pkg::PAGE_SHIFT);
                    n_state    = pba_pkg::S_RESULT;
                end else if (r_cur == LAST_WORD) begin
                    n_res_st = pba_pkg::ST_FULL;
                    n_state  = pba_pkg::S_RESULT;
                end else begin
                    n_cur = AW'(r_cur + AW'(1));
                end
            end
            pba_pkg::S_FREE: begin
                w_en    = 1'b1;
                w_data  = r_rdata & ~(32'd1 << r_bit);
                n_state = pba_pkg::S_RESULT;
            end
            pba_pkg::S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.result_address = r_res_addr;
                    n_out.status         = r_res_st;
                    n_state              = pba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pba_pkg::S_SWEEP;
            r_cur       <= '0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pool_base <= pba_pkg::POOL_BASE_RESET;
            r_reserved  <= '0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == pba_pkg::CFG_POOL_BASE) begin
                    r_pool_base <= i_cfg_wdata;
                end else begin
                    r_reserved <= i_cfg_wdata[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit      <= n_bit;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[rd_addr];
    end

    `ASSERT_ALWAYS(a_reset_sweep, i_clk, !i_rst_n |=> r_state == pba_pkg::S_SWEEP, "Reset did not start the clearing pass.")
    `ASSERT_CHECK(a_write_state, i_clk, i_rst_n, w_en |-> (r_state == pba_pkg::S_SWEEP || r_state == pba_pkg::S_SCAN || r_state == pba_pkg::S_FREE), "Bitmap written outside a write state.")
    `ASSERT_CHECK(a_full_zero, i_clk, i_rst_n, (r_out_valid && r_out.status == pba_pkg::ST_FULL) |-> r_out.result_address == 32'd0, "Full status with nonzero address.")
    `ASSERT_CHECK(a_scan_step, i_clk, i_rst_n, (r_state == pba_pkg::S_SCAN) ##1 (r_state == pba_pkg::S_SCAN) |-> r_cur == AW'($past(r_cur) + AW'(1)), "Scan skipped or repeated a word.")

endmodule

`default_nettype wire
